// ===== design/fkvc_pkg.sv =====
// ============================================================================
// fkvc_pkg: shared constants and types for the FIFO key-value cache
// Sizes of the entry store, operation codes and the command and status
// bundles that pass between the controller and the datapath.
// ============================================================================
package fkvc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int EFF_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic             OP_GET     = 1'b0;
    localparam logic             OP_PUT     = 1'b1;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef struct packed {
        logic capture;      // latch the request and register the key match
        logic evict;        // drop the oldest entry, shift the rest down
        logic move;         // drop the hit entry and append it as newest
        logic append;       // append the request as the newest entry
        logic load_result;  // load the output register
    } t_ctrl_cmd;

    typedef struct packed {
        logic op;           // operation of the request in flight
        logic hit;          // key was present at capture
        logic cap_zero;     // capacity register is zero
        logic need_evict;   // entry count has reached the effective capacity
    } t_ctrl_status;

endpackage

// ===== design/fkvc_datapath.sv =====
// ============================================================================
// fkvc_datapath: entry store, key match and result register
// Holds the entries packed in age order (slot 0 oldest), compares a key
// against all of them, and shifts, moves or appends entries on command.
// ============================================================================
module fkvc_datapath
    import fkvc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CAP_W-1:0]        i_cfg_wdata,
    input  logic                    i_operation,
    input  logic signed [KEY_W-1:0] i_lookup_key,
    input  logic signed [VAL_W-1:0] i_store_value,
    input  t_ctrl_cmd               i_cmd,
    output t_ctrl_status            o_status,
    output logic                    o_hit,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic                    o_stored,
    output logic                    o_evicted,
    output logic signed [KEY_W-1:0] o_evicted_key
);

    logic [KEY_W-1:0]       r_keys   [MAX_ENTRIES];
    logic [VAL_W-1:0]       r_values [MAX_ENTRIES];
    logic [CNT_W-1:0]       r_count;
    logic [CAP_W-1:0]       r_cap;

    logic                   r_op;
    logic [KEY_W-1:0]       r_key;
    logic [VAL_W-1:0]       r_value;
    logic                   r_hit;
    logic [IDX_W-1:0]       r_found;
    logic                   r_evicted;
    logic [KEY_W-1:0]       r_evicted_key;

    logic                   r_out_hit;
    logic [VAL_W-1:0]       r_out_read_value;
    logic                   r_out_stored;
    logic                   r_out_evicted;
    logic [KEY_W-1:0]       r_out_evicted_key;

    logic [MAX_ENTRIES-1:0] match;
    logic [IDX_W-1:0]       match_idx;
    logic [EFF_W-1:0]       cnt_ext;
    logic [EFF_W-1:0]       cap_ext;
    logic [EFF_W-1:0]       cap_eff;
    logic [CNT_W-1:0]       last_slot;
    logic [CNT_W-1:0]       found_ext;

    // Key match against every occupied slot; the lowest slot wins.
    always_comb begin
        match_idx = '0;
        for (int g = 0; g < MAX_ENTRIES; g++) begin
            match[g] = (CNT_W'(g) < r_count) && (r_keys[g] == i_lookup_key);
        end
        for (int g = MAX_ENTRIES - 1; g >= 0; g--) begin
            if (match[g]) begin
                match_idx = IDX_W'(g);
            end
        end
    end

    assign cnt_ext   = EFF_W'(r_count);
    assign cap_ext   = EFF_W'(r_cap);
    assign cap_eff   = (cap_ext > EFF_W'(MAX_ENTRIES)) ? EFF_W'(MAX_ENTRIES) : cap_ext;
    assign last_slot = r_count - CNT_W'(1);
    assign found_ext = CNT_W'(r_found);

    assign o_status.op         = r_op;
    assign o_status.hit        = r_hit;
    assign o_status.cap_zero   = (r_cap == '0);
    assign o_status.need_evict = (cnt_ext >= cap_eff) && (r_count != '0);

    // Per-slot storage: each slot takes its upper neighbor on a shift or
    // the request's key and value on a load.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_slot
        localparam int UP = (g + 1 < MAX_ENTRIES) ? g + 1 : g;
        logic shift_in;
        logic load_new;

        assign shift_in = i_cmd.evict ||
                          (i_cmd.move && (CNT_W'(g) >= found_ext) && (CNT_W'(g) < last_slot));
        assign load_new = (i_cmd.move && (CNT_W'(g) == last_slot)) ||
                          (i_cmd.append && (CNT_W'(g) == r_count));

        always_ff @(posedge i_clk) begin
            if (load_new) begin
                r_keys[g]   <= r_key;
                r_values[g] <= r_value;
            end else if (shift_in) begin
                r_keys[g]   <= r_keys[UP];
                r_values[g] <= r_values[UP];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.evict) begin
                r_count <= r_count - CNT_W'(1);
            end else if (i_cmd.append) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op          <= i_operation;
            r_key         <= i_lookup_key;
            r_value       <= i_store_value;
            r_hit         <= |match;
            r_found       <= match_idx;
            r_evicted     <= 1'b0;
            r_evicted_key <= '0;
        end else if (i_cmd.evict && !r_evicted) begin
            r_evicted     <= 1'b1;
            r_evicted_key <= r_keys[0];
        end
        if (i_cmd.load_result) begin
            r_out_hit         <= r_hit;
            r_out_read_value  <= (r_op == OP_GET && r_hit) ? r_values[r_found] : MISS_VALUE;
            r_out_stored      <= (r_op == OP_PUT) && (r_cap != '0);
            r_out_evicted     <= r_evicted;
            r_out_evicted_key <= r_evicted_key;
        end
    end

    assign o_hit         = r_out_hit;
    assign o_read_value  = r_out_read_value;
    assign o_stored      = r_out_stored;
    assign o_evicted     = r_out_evicted;
    assign o_evicted_key = r_out_evicted_key;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above the store depth");

    a_evict_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.evict |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("eviction did not remove exactly one entry");

    a_move_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.move |=> $stable(r_count))
        else $error("moving a hit entry changed the entry count");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> r_count < CNT_W'(MAX_ENTRIES))
        else $error("append into a full store");

endmodule

// ===== design/fkvc_controller.sv =====
// ============================================================================
// fkvc_controller: request sequencer for the FIFO key-value cache
// Accepts a request, then issues evictions one a cycle as needed and a
// final move or append together with the result load.
// ============================================================================
module fkvc_controller
    import fkvc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_ACT  = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic put_new;
    logic put_hit;

    assign put_new = (i_status.op == OP_PUT) && !i_status.hit && !i_status.cap_zero;
    assign put_hit = (i_status.op == OP_PUT) && i_status.hit && !i_status.cap_zero;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_ACT;
                end
            end
            S_ACT: begin
                if (put_new && i_status.need_evict) begin
                    o_cmd.evict = 1'b1;
                end else if (!r_out_valid || i_out_ready) begin
                    o_cmd.move        = put_hit;
                    o_cmd.append      = put_new;
                    o_cmd.load_result = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_append_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.append |-> !i_status.need_evict)
        else $error("append issued while the cache is still at capacity");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_result && r_out_valid |-> i_out_ready)
        else $error("result register overwritten before it was taken");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_result |=> r_out_valid && r_state == S_IDLE)
        else $error("result load did not finish the request");

endmodule

// ===== design/fifo_key_value_cache_unit.sv =====
// Timing: the key match is registered with the accepted item, and its result
// goes to the output register in the update step, once that register is free.
// An item is taken only after the previous one is updated (an accept step with
// the key match, then an update step); a put of a new key into a full cache
// adds an eviction step per evicted entry; a held result stalls the update.
// Reset: synchronous active-low reset empties the cache and sets capacity to 16.
// ============================================================================
// fifo_key_value_cache_unit: key-value cache with first-in-first-out eviction
// A get looks up a key; a put stores a key and value unless the capacity is zero,
// evicting the oldest entry when the cache holds its configured capacity.
// ============================================================================
module fifo_key_value_cache_unit
    import fkvc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Capacity register write port.
    input  logic                    i_cfg_we,
    input  logic [CAP_W-1:0]        i_cfg_wdata,
    // Request channel.
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_operation,
    input  logic signed [KEY_W-1:0] i_lookup_key,
    input  logic signed [VAL_W-1:0] i_store_value,
    // Result channel.
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_hit,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic                    o_stored,
    output logic                    o_evicted,
    output logic signed [KEY_W-1:0] o_evicted_key
);

    // The entries live in the datapath as a row of registers kept in age
    // order, with slot 0 holding the oldest entry. The key match runs in the
    // cycle in which an item is accepted, directly on the input key, and its
    // outcome (hit flag and lowest matching slot) is registered with the item.
    //
    // Once the item is registered, the controller issues a single update. A put to
    // a present key closes the gap left by the hit slot and writes the item
    // into the newest slot. A put to a new key appends it behind the newest
    // entry. When the cache already holds its capacity, the controller first
    // shifts the whole row down by one slot per cycle until there is room,
    // which in normal use is a single shift; the first key shifted out is the
    // one reported as evicted.
    //
    // The result goes into an output register, so the next item can be
    // accepted while the previous result still waits to be taken; the update
    // cycle of that next item simply holds until the register is free.

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    fkvc_controller u_controller (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    fkvc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_operation   (i_operation),
        .i_lookup_key  (i_lookup_key),
        .i_store_value (i_store_value),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_stored      (o_stored),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

endmodule
